FILE: rtl/harmonic_sine_synthesizer_core_macros.svh
// Assertion macros shared by the harmonic sine synthesiser modules.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef HARMONIC_SINE_SYNTHESIZER_CORE_MACROS_SVH
`define HARMONIC_SINE_SYNTHESIZER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hss assertion failed");

// Next-cycle implication, checked outside reset.
`define HSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hss assertion failed");

`endif

FILE: rtl/hss_pkg.sv
// Shared constants, types and the quarter-wave sine table of the harmonic synthesiser.
// Used by hss_ctrl, hss_dp and harmonic_sine_synthesizer_core; depends on nothing.
package hss_pkg;

  // Block dimensions.
  localparam int MAX_HARMONICS   = 8;
  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;

  localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;
  localparam int HARM_W       = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int CNT_W        = $clog2(MAX_HARMONICS + 1);

  // Field and arithmetic widths.
  localparam int MAG_W       = 15;
  localparam int SINE_W      = MAG_W + 1;
  localparam int GAIN_W      = 16;
  localparam int WEIGHT_W    = 8;
  localparam int MULT_W      = 4;
  localparam int COUNT_W     = 4;
  localparam int AMP_W       = GAIN_W + WEIGHT_W;
  localparam int TERM_W      = AMP_W + MAG_W + 1;
  localparam int SUM_W       = TERM_W + $clog2(MAX_HARMONICS) + 1;
  localparam int ROUND_SHIFT = 25;
  localparam int RED_W       = SUM_W - ROUND_SHIFT;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd16384;
  localparam logic [COUNT_W-1:0] COUNT_RST = 4'd8;
  localparam logic [31:0]        MULTS_RST = 32'h8765_4321;

  // Polynomial coefficients of the sine, Q30.
  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598523;
  localparam logic [63:0] C5 = 64'd85569099;
  localparam logic [63:0] C7 = 64'd5027003;
  localparam logic [63:0] C9 = 64'd172271;
  localparam logic [63:0] MAG_MAX = 64'd32767;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PHASE_STEP  = 3'd0,
    REG_START_PHASE = 3'd1,
    REG_GAIN        = 3'd2,
    REG_COUNT       = 3'd3,
    REG_MULTS       = 3'd4,
    REG_WEIGHTS     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_ROUND
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic              start;
    logic              issue;
    logic [HARM_W-1:0] harm;
    logic              load_out;
  } hss_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             busy;
    logic             out_busy;
  } hss_status_t;

  typedef logic [QUARTER-1:0][MAG_W-1:0] qsine_tab_t;

  // sin(pi/2 * j / QUARTER) in Q0.15 via a degree-nine odd polynomial in Q30.
  function automatic logic [MAG_W-1:0] quarter_sine(input logic [QUARTER_BITS:0] j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] v;
    x  = 64'(j) << (30 - QUARTER_BITS);
    x2 = (x * x) >> 30;
    r  = C9;
    r  = C7 - ((x2 * r) >> 30);
    r  = C5 - ((x2 * r) >> 30);
    r  = C3 - ((x2 * r) >> 30);
    r  = C1 - ((x2 * r) >> 30);
    s  = (x * r) >> 30;
    v  = (s * MAG_MAX + (64'd1 << 29)) >> 30;
    if (v > MAG_MAX) begin
      v = MAG_MAX;
    end
    return v[MAG_W-1:0];
  endfunction

  function automatic qsine_tab_t build_qsine_tab();
    qsine_tab_t tab;
    for (int i = 0; i < QUARTER; i++) begin
      tab[i] = quarter_sine((QUARTER_BITS + 1)'(i));
    end
    return tab;
  endfunction

  // Quarter-wave table for j = 0 .. QUARTER-1, and the peak at j = QUARTER.
  localparam qsine_tab_t        QSINE_TAB  = build_qsine_tab();
  localparam logic [MAG_W-1:0]  QSINE_PEAK = quarter_sine((QUARTER_BITS + 1)'(QUARTER));

endpackage

FILE: rtl/hss_ctrl.sv
// Sequencing state machine of the harmonic synthesiser: accepts a beat, issues one
// harmonic per cycle, drains the datapath and loads the result. Depends on hss_pkg.
`include "harmonic_sine_synthesizer_core_macros.svh"

module hss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hss_pkg::hss_status_t status_i,
  output hss_pkg::hss_cmd_t    cmd_o
);

  hss_pkg::state_e                state_q, state_d;
  logic [hss_pkg::CNT_W-1:0]      k_q, k_d;
  logic                           accept;
  logic                           last_issue;

  assign accept     = in_valid_i && (state_q == hss_pkg::ST_IDLE);
  assign last_issue = ((k_q + 1'b1) == status_i.count);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hss_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (status_i.count == '0) ? hss_pkg::ST_DRAIN : hss_pkg::ST_ISSUE;
        end
      end
      hss_pkg::ST_ISSUE: begin
        if (last_issue) begin
          state_d = hss_pkg::ST_DRAIN;
        end
      end
      hss_pkg::ST_DRAIN: begin
        if (!status_i.busy) begin
          state_d = hss_pkg::ST_ROUND;
        end
      end
      hss_pkg::ST_ROUND: begin
        if (!status_i.out_busy) begin
          state_d = hss_pkg::ST_IDLE;
        end
      end
      default: state_d = hss_pkg::ST_IDLE;
    endcase
  end

  // Outputs and harmonic counter.
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.start    = 1'b0;
    cmd_o.issue    = 1'b0;
    cmd_o.harm     = k_q[hss_pkg::HARM_W-1:0];
    cmd_o.load_out = 1'b0;
    k_d            = k_q;
    unique case (state_q)
      hss_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = accept;
        k_d         = '0;
      end
      hss_pkg::ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        k_d         = k_q + 1'b1;
      end
      hss_pkg::ST_DRAIN: begin
        k_d = k_q;
      end
      hss_pkg::ST_ROUND: begin
        cmd_o.load_out = !status_i.out_busy;
      end
      default: begin
        k_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hss_pkg::ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // A beat taken always starts work on it.
  `HSS_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != hss_pkg::ST_IDLE)
  // Harmonics are only issued below the programmed count.
  `HSS_ASSERT_IMPL(a_issue_in_range, cmd_o.issue, k_q < status_i.count)
  // Rounding only sees a fully drained pipeline.
  `HSS_ASSERT_IMPL(a_round_drained, state_q == hss_pkg::ST_ROUND, !status_i.busy)

endmodule

FILE: rtl/hss_dp.sv
// Datapath of the harmonic synthesiser: configuration registers, phase accumulator,
// harmonic phase, sine lookup, multiply-accumulate and output register. Depends on hss_pkg.
`include "harmonic_sine_synthesizer_core_macros.svh"

module hss_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hss_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [hss_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              restart_i,
  input  hss_pkg::hss_cmd_t                 cmd_i,
  output hss_pkg::hss_status_t              status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [hss_pkg::SAMPLE_W-1:0] sample_o
);

  localparam int PB = hss_pkg::PHASE_BITS;
  localparam int SB = hss_pkg::SINE_TABLE_BITS;
  localparam int QB = hss_pkg::QUARTER_BITS;

  // Configuration registers.
  logic [PB-1:0]                    step_q;
  logic [PB-1:0]                    start_phase_q;
  logic [hss_pkg::GAIN_W-1:0]       gain_q;
  logic [hss_pkg::COUNT_W-1:0]      count_q;
  logic [31:0]                      mults_q;
  logic [63:0]                      weights_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= '0;
      start_phase_q <= '0;
      gain_q        <= hss_pkg::GAIN_RST;
      count_q       <= hss_pkg::COUNT_RST;
      mults_q       <= hss_pkg::MULTS_RST;
      weights_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (hss_pkg::cfg_reg_e'(cfg_addr_i))
        hss_pkg::REG_PHASE_STEP:  step_q        <= cfg_wdata_i[PB-1:0];
        hss_pkg::REG_START_PHASE: start_phase_q <= cfg_wdata_i[PB-1:0];
        hss_pkg::REG_GAIN:        gain_q        <= cfg_wdata_i[hss_pkg::GAIN_W-1:0];
        hss_pkg::REG_COUNT:       count_q       <= cfg_wdata_i[hss_pkg::COUNT_W-1:0];
        hss_pkg::REG_MULTS:       mults_q       <= cfg_wdata_i[31:0];
        hss_pkg::REG_WEIGHTS:     weights_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Harmonic count clamped to the number of entries.
  logic [hss_pkg::CNT_W-1:0] count_clamped;
  assign count_clamped = (count_q > hss_pkg::COUNT_W'(hss_pkg::MAX_HARMONICS)) ?
                         hss_pkg::CNT_W'(hss_pkg::MAX_HARMONICS) :
                         hss_pkg::CNT_W'(count_q);

  // Phase accumulator: the sample phase is latched and the accumulator advanced per beat.
  logic [PB-1:0] acc_q;
  logic [PB-1:0] ph_q;
  logic [PB-1:0] ph_d;

  assign ph_d = restart_i ? start_phase_q : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.start) begin
      acc_q <= ph_d + step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ph_q <= ph_d;
    end
  end

  // Stage A: harmonic phase and weight selection.
  logic [hss_pkg::MULT_W-1:0]   mult_sel;
  logic [PB+hss_pkg::MULT_W-1:0] hprod;
  logic [SB-1:0]                hidx_q;
  logic [hss_pkg::WEIGHT_W-1:0] wsel_q;
  logic                         v1_q;

  assign mult_sel = mults_q[{cmd_i.harm, 2'b00} +: hss_pkg::MULT_W];
  assign hprod    = (PB + hss_pkg::MULT_W)'(ph_q) * (PB + hss_pkg::MULT_W)'(mult_sel);

  always_ff @(posedge clk_i) begin
    hidx_q <= hprod[PB-1 -: SB];
    wsel_q <= weights_q[{cmd_i.harm, 3'b000} +: hss_pkg::WEIGHT_W];
  end

  // Stage B: sine from the quarter table by symmetry, and the amplitude.
  logic [1:0]                         quad;
  logic [QB-1:0]                      jj;
  logic [QB-1:0]                      taddr;
  logic [hss_pkg::MAG_W-1:0]          mag;
  logic signed [hss_pkg::SINE_W-1:0]  sine_q;
  logic signed [hss_pkg::SINE_W-1:0]  sine_d;
  logic [hss_pkg::AMP_W-1:0]          amp_q;
  logic                               v2_q;

  assign quad   = hidx_q[SB-1 -: 2];
  assign jj     = hidx_q[QB-1:0];
  assign taddr  = quad[0] ? (QB'(0) - jj) : jj;
  assign mag    = (quad[0] && (jj == '0)) ? hss_pkg::QSINE_PEAK : hss_pkg::QSINE_TAB[taddr];
  assign sine_d = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_ff @(posedge clk_i) begin
    sine_q <= sine_d;
    amp_q  <= hss_pkg::AMP_W'(gain_q) * hss_pkg::AMP_W'(wsel_q);
  end

  // Stage C: term = amplitude times sine, Q3.37.
  logic signed [hss_pkg::TERM_W:0]    term_full;
  logic signed [hss_pkg::TERM_W-1:0]  term_q;
  logic                               v3_q;

  assign term_full = $signed({1'b0, amp_q}) * sine_q;

  always_ff @(posedge clk_i) begin
    term_q <= term_full[hss_pkg::TERM_W-1:0];
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Accumulator of the terms, cleared when a beat is taken.
  logic signed [hss_pkg::SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sum_q <= '0;
    end else if (v3_q) begin
      sum_q <= sum_q + {{(hss_pkg::SUM_W - hss_pkg::TERM_W){term_q[hss_pkg::TERM_W-1]}},
                        term_q};
    end
  end

  // Round to Q4.12 (half up, floor shift) and saturate to 16 bits.
  logic signed [hss_pkg::SUM_W-1:0]    rsum;
  logic signed [hss_pkg::RED_W-1:0]    red;
  logic signed [hss_pkg::SAMPLE_W-1:0] sat;

  assign rsum = sum_q + (hss_pkg::SUM_W'(1) << (hss_pkg::ROUND_SHIFT - 1));
  assign red  = rsum[hss_pkg::SUM_W-1:hss_pkg::ROUND_SHIFT];

  always_comb begin
    priority if (!red[hss_pkg::RED_W-1] &&
                 (|red[hss_pkg::RED_W-2:hss_pkg::SAMPLE_W-1])) begin
      sat = {1'b0, {(hss_pkg::SAMPLE_W-1){1'b1}}};
    end else if (red[hss_pkg::RED_W-1] &&
                 !(&red[hss_pkg::RED_W-2:hss_pkg::SAMPLE_W-1])) begin
      sat = {1'b1, {(hss_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      sat = red[hss_pkg::SAMPLE_W-1:0];
    end
  end

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sample_o <= sat;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.count    = count_clamped;
  assign status_o.busy     = v1_q || v2_q || v3_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  // The output register is only reloaded once its beat has gone.
  `HSS_ASSERT_IMPL(a_load_when_free, cmd_i.load_out, !(out_valid_q && !out_ready_i))
  // A new beat never clears the sum under terms still in flight.
  `HSS_ASSERT_IMPL(a_start_pipe_empty, cmd_i.start, !v1_q && !v2_q && !v3_q)
  // Without restart the accumulator advances by exactly one step.
  `HSS_ASSERT_NEXT(a_acc_advance, cmd_i.start && !restart_i, acc_q == $past(acc_q + step_q))

endmodule

FILE: rtl/harmonic_sine_synthesizer_core.sv
// Harmonic sine synthesiser: one Q4.12 sample per input beat, the sum of N harmonics with
// N = min(harmonic_count, 8). A new beat is taken only once the previous sample has been
// loaded into the output register, so the one shared sine-and-MAC pass per harmonic plus
// output stalls set the rate; when the count is zero no harmonic is issued.
// Asynchronous active-low reset loads the register defaults and clears the phase
// accumulator and all control state; no clearing pass is needed.
module harmonic_sine_synthesizer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [hss_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [hss_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [hss_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [0] restart, [7:1] zero
  // Output stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [hss_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // [15:0] sample
);

  hss_pkg::hss_cmd_t                  cmd;
  hss_pkg::hss_status_t               status;
  logic signed [hss_pkg::SAMPLE_W-1:0] sample;

  // Sequencer.
  hss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  hss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .restart_i   (s_axis_tdata[0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sample_o    (sample)
  );

  assign m_axis_tdata = sample;

endmodule
